// ----- hdl/pha_pkg.sv -----
// shared types, constants and lookup tables for the pixel hsv adjust core
package pha_pkg;

    // working format: unsigned 1.16 fixed point, values 0..ONE inclusive
    localparam int FRAC = 16;
    localparam int CW = FRAC + 1;
    localparam logic [CW-1:0] ONE = 17'h10000;

    // hue numerator and six times the chroma span fit in 19 bits
    localparam int HW = 19;

    typedef logic [CW-1:0] chan_t;
    typedef logic [2:0][CW-1:0] rgb_t;
    typedef logic [CW-1:0] lut_t [256];

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } pixel_out_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_HUE_SETTING     = 3'd0,
        REG_SATURATION_GAIN = 3'd1,
        REG_VALUE_GAIN      = 3'd2,
        REG_BLEND_WEIGHT    = 3'd3,
        REG_SOURCE_IS_SRGB  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [16:0] hue_setting;
        logic [15:0] saturation_gain;
        logic [15:0] value_gain;
        logic [16:0] blend_weight;
        logic        source_is_srgb;
    } cfg_t;

    // data that rides along the divider stages
    typedef struct packed {
        rgb_t       lin;
        chan_t      mx;
        logic [7:0] alpha;
        logic       grey;
    } side_t;

    typedef struct packed {
        side_t         side;
        logic [HW-1:0] hue_num;
        logic [HW-1:0] hue_den;
        chan_t         sat_num;
    } div_in_t;

    typedef struct packed {
        side_t       side;
        logic [15:0] hue;
        chan_t       sat;
    } hsv_t;

    // srgb to linear decode, units 2^-16
    function automatic lut_t build_srgb_lut();
        lut_t        lut;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] m2;
        logic [63:0] m4;
        logic [63:0] m5;
        logic [63:0] lin;
        for (int i = 0; i < 256; i++) begin
            if (i <= 10) begin
                lut[i] = CW'((64'(i) * 64'd6553600 + 64'd164730) / 64'd329460);
            end else if (i == 255) begin
                lut[i] = ONE;
            end else begin
                t = (64'(1000 * i + 14025) << 32) / 64'd269025;
                s = (t * t) >> 32;
                lo = 64'd0;
                hi = 64'hFFFF_FFFF;
                // largest q32 value whose fifth power stays at or below s
                while (lo < hi) begin
                    mid = lo + ((hi - lo + 64'd1) >> 1);
                    m2 = (mid * mid) >> 32;
                    m4 = (m2 * m2) >> 32;
                    m5 = (m4 * mid) >> 32;
                    if (m5 <= s) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
                lin = (s * lo) >> 32;
                lut[i] = CW'((lin + 64'd32768) >> 16);
            end
        end
        return lut;
    endfunction

    // plain byte to 1.16, rounded
    function automatic lut_t build_plain_lut();
        lut_t lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = CW'((64'(i) * 64'd131072 + 64'd255) / 64'd510);
        end
        return lut;
    endfunction

    localparam lut_t SRGB_LUT = build_srgb_lut();
    localparam lut_t PLAIN_LUT = build_plain_lut();

endpackage

// ----- hdl/pha_front.sv -----
// front stages: linearize, max/min search, hue numerator and divisor setup
module pha_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  pha_pkg::pixel_in_t  pixel,
    input  pha_pkg::cfg_t       cfg,
    output logic                out_valid,
    output pha_pkg::div_in_t    dout
);

    logic [2:0]         v_reg;
    pha_pkg::rgb_t      lin1_reg;
    logic [7:0]         alpha1_reg;
    pha_pkg::rgb_t      lin1_next;
    pha_pkg::rgb_t      lin2_reg;
    logic [7:0]         alpha2_reg;
    pha_pkg::chan_t     mx2_reg;
    pha_pkg::chan_t     mn2_reg;
    logic               gb2_reg;
    logic               rmax2_reg;
    pha_pkg::chan_t     mx2_next;
    pha_pkg::chan_t     mn2_next;
    logic               gb2_next;
    logic               rmax2_next;
    pha_pkg::chan_t     pmax;
    pha_pkg::chan_t     pmin;
    pha_pkg::div_in_t   d3_reg;
    pha_pkg::div_in_t   d3_next;
    pha_pkg::chan_t     span;
    logic [pha_pkg::HW-1:0] span_w;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    // stage 1: byte to linear through the selected table
    always_comb
    begin
        if (cfg.source_is_srgb)
        begin
            lin1_next[0] = pha_pkg::SRGB_LUT[pixel.red_in];
            lin1_next[1] = pha_pkg::SRGB_LUT[pixel.green_in];
            lin1_next[2] = pha_pkg::SRGB_LUT[pixel.blue_in];
        end
        else
        begin
            lin1_next[0] = pha_pkg::PLAIN_LUT[pixel.red_in];
            lin1_next[1] = pha_pkg::PLAIN_LUT[pixel.green_in];
            lin1_next[2] = pha_pkg::PLAIN_LUT[pixel.blue_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin1_reg <= lin1_next;
            alpha1_reg <= pixel.alpha_in;
        end
    end

    // stage 2: max and min of the three channels
    always_comb
    begin
        gb2_next = lin1_reg[1] >= lin1_reg[2];
        pmax = gb2_next ? lin1_reg[1] : lin1_reg[2];
        pmin = gb2_next ? lin1_reg[2] : lin1_reg[1];
        rmax2_next = lin1_reg[0] >= pmax;
        mx2_next = rmax2_next ? lin1_reg[0] : pmax;
        if (rmax2_next)
        begin
            mn2_next = pmin;
        end
        else
        begin
            mn2_next = (lin1_reg[0] < pmin) ? lin1_reg[0] : pmin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin2_reg <= lin1_reg;
            alpha2_reg <= alpha1_reg;
            mx2_reg <= mx2_next;
            mn2_reg <= mn2_next;
            gb2_reg <= gb2_next;
            rmax2_reg <= rmax2_next;
        end
    end

    // stage 3: chroma span, sector numerator, divisor
    always_comb
    begin
        span = mx2_reg - mn2_reg;
        span_w = pha_pkg::HW'(span);
        d3_next.side.lin = lin2_reg;
        d3_next.side.mx = mx2_reg;
        d3_next.side.alpha = alpha2_reg;
        d3_next.side.grey = (span == '0);
        d3_next.sat_num = span;
        d3_next.hue_den = (span_w << 2) + (span_w << 1);
        if (rmax2_reg)
        begin
            if (gb2_reg)
            begin
                d3_next.hue_num = pha_pkg::HW'(lin2_reg[1] - lin2_reg[2]);
            end
            else
            begin
                d3_next.hue_num = d3_next.hue_den
                                  - pha_pkg::HW'(lin2_reg[2] - lin2_reg[1]);
            end
        end
        else if (gb2_reg)
        begin
            d3_next.hue_num = (span_w << 1) + pha_pkg::HW'(lin2_reg[2])
                              - pha_pkg::HW'(lin2_reg[0]);
        end
        else
        begin
            d3_next.hue_num = (span_w << 2) + pha_pkg::HW'(lin2_reg[0])
                              - pha_pkg::HW'(lin2_reg[1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_reg <= d3_next;
        end
    end

    assign out_valid = v_reg[2];
    assign dout = d3_reg;

endmodule

// ----- hdl/pha_hsdiv.sv -----
// pipelined restoring dividers for hue and saturation, one quotient bit per stage
module pha_hsdiv (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  pha_pkg::div_in_t  din,
    output logic              out_valid,
    output pha_pkg::hsv_t     dout
);

    localparam int STEPS = pha_pkg::CW;
    localparam int RW = pha_pkg::HW + 1;
    localparam int LAST = STEPS - 1;

    logic                   v_reg    [STEPS];
    logic [RW-1:0]          hrem_reg [STEPS];
    logic [RW-1:0]          srem_reg [STEPS];
    logic [pha_pkg::HW-1:0] hden_reg [STEPS];
    logic [STEPS-1:0]       hq_reg   [STEPS];
    logic [STEPS-1:0]       sq_reg   [STEPS];
    pha_pkg::side_t         side_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [RW-1:0]          hrem_next;
        logic [RW-1:0]          srem_next;
        logic [RW-1:0]          hden_w;
        logic [RW-1:0]          sden_w;
        logic [pha_pkg::HW-1:0] hden_next;
        logic [STEPS-1:0]       hq_next;
        logic [STEPS-1:0]       sq_next;
        pha_pkg::side_t         side_next;
        logic                   v_next;

        // first step takes the dividend as is, later ones shift the remainder
        if (k == 0)
        begin : g_first
            assign hrem_next = RW'(din.hue_num);
            assign srem_next = RW'(din.sat_num);
            assign hden_next = din.hue_den;
            assign hq_next = '0;
            assign sq_next = '0;
            assign side_next = din.side;
            assign v_next = in_valid;
        end
        else
        begin : g_next
            assign hrem_next = {hrem_reg[k-1][RW-2:0], 1'b0};
            assign srem_next = {srem_reg[k-1][RW-2:0], 1'b0};
            assign hden_next = hden_reg[k-1];
            assign hq_next = hq_reg[k-1];
            assign sq_next = sq_reg[k-1];
            assign side_next = side_reg[k-1];
            assign v_next = v_reg[k-1];
        end

        assign hden_w = RW'(hden_next);
        assign sden_w = RW'(side_next.mx);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_next;
            end
        end

        // compare and subtract, one quotient bit per lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hden_reg[k] <= hden_next;
                side_reg[k] <= side_next;
                if (hrem_next >= hden_w)
                begin
                    hrem_reg[k] <= hrem_next - hden_w;
                    hq_reg[k] <= {hq_next[STEPS-2:0], 1'b1};
                end
                else
                begin
                    hrem_reg[k] <= hrem_next;
                    hq_reg[k] <= {hq_next[STEPS-2:0], 1'b0};
                end
                if (srem_next >= sden_w)
                begin
                    srem_reg[k] <= srem_next - sden_w;
                    sq_reg[k] <= {sq_next[STEPS-2:0], 1'b1};
                end
                else
                begin
                    srem_reg[k] <= srem_next;
                    sq_reg[k] <= {sq_next[STEPS-2:0], 1'b0};
                end
            end
        end
    end

    // grey texel forces hue and saturation to zero
    always_comb
    begin
        dout.side = side_reg[LAST];
        if (side_reg[LAST].grey)
        begin
            dout.hue = '0;
            dout.sat = '0;
        end
        else
        begin
            dout.hue = hq_reg[LAST][15:0];
            dout.sat = sq_reg[LAST];
        end
    end

    assign out_valid = v_reg[LAST];

`ifndef ASSERT_OFF
    a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST] && !side_reg[LAST].grey |-> hrem_reg[LAST] < RW'(hden_reg[LAST]))
        else $error("hue remainder not below divisor");
    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST] && !side_reg[LAST].grey |-> srem_reg[LAST] < RW'(side_reg[LAST].mx))
        else $error("saturation remainder not below divisor");
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST] && !side_reg[LAST].grey |-> !hq_reg[LAST][STEPS-1])
        else $error("hue quotient reached one");
`endif

endmodule

// ----- hdl/pha_back.sv -----
// back stages: hue rotate, gains, hsv to rgb, blend and byte saturation
module pha_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  pha_pkg::hsv_t       hsv,
    input  pha_pkg::cfg_t       cfg,
    output logic                out_valid,
    output pha_pkg::pixel_out_t pixel
);

    localparam logic [18:0] ONE3 = 19'(3 * 65536);
    localparam logic [19:0] ONE4 = 20'(4 * 65536);
    localparam logic [19:0] ONE2 = 20'(2 * 65536);
    localparam logic [19:0] ONE6 = 20'(6 * 65536);

    logic [6:0]             v_reg;
    pha_pkg::rgb_t          lin_reg [6];
    logic [7:0]             alpha_reg [6];

    logic [15:0]            hue1_reg;
    logic [32:0]            sprod1_reg;
    logic [32:0]            vprod1_reg;
    pha_pkg::chan_t         sat2_reg;
    pha_pkg::chan_t         val2_reg;
    logic [2:0][18:0]       t2_reg;
    pha_pkg::chan_t         sat2_next;
    pha_pkg::chan_t         val2_next;
    logic [2:0][18:0]       t2_next;
    logic [19:0]            tr_w;
    logic [19:0]            tg_w;
    logic [19:0]            tb_w;
    pha_pkg::chan_t         sat3_reg;
    pha_pkg::chan_t         val3_reg;
    pha_pkg::rgb_t          ramp3_reg;
    pha_pkg::rgb_t          ramp3_next;
    logic [17:0]            pdist;
    pha_pkg::chan_t         val4_reg;
    pha_pkg::rgb_t          m4_reg;
    pha_pkg::rgb_t          m4_next;
    logic [33:0]            mprod;
    pha_pkg::rgb_t          adj5_reg;
    pha_pkg::rgb_t          adj5_next;
    logic [33:0]            cprod;
    logic signed [36:0]     pa6_reg [3];
    logic [33:0]            pb6_reg [3];
    logic signed [18:0]     wneg;
    logic [7:0]             out7_reg [3];
    logic [7:0]             out7_next [3];
    logic [7:0]             alpha7_reg;
    logic signed [37:0]     num;
    logic [45:0]            scaled;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    // original linear colour and alpha follow the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg[0] <= hsv.side.lin;
            alpha_reg[0] <= hsv.side.alpha;
            for (int s = 1; s < 6; s++)
            begin
                lin_reg[s] <= lin_reg[s-1];
                alpha_reg[s] <= alpha_reg[s-1];
            end
        end
    end

    // stage 1: hue rotation and gain products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue1_reg <= hsv.hue + {cfg.hue_setting[14:0], 1'b0};
            sprod1_reg <= hsv.sat * cfg.saturation_gain;
            vprod1_reg <= hsv.side.mx * cfg.value_gain;
        end
    end

    // stage 2: clamp gains, sector positions of the three channels
    always_comb
    begin
        sat2_next = (sprod1_reg[32:8] > 25'(pha_pkg::ONE)) ? pha_pkg::ONE : sprod1_reg[24:8];
        val2_next = (vprod1_reg[32:8] > 25'(pha_pkg::ONE)) ? pha_pkg::ONE : vprod1_reg[24:8];
        tr_w = (20'(hue1_reg) << 2) + (20'(hue1_reg) << 1);
        tg_w = tr_w + ONE4;
        tb_w = tr_w + ONE2;
        if (tg_w >= ONE6)
        begin
            tg_w = tg_w - ONE6;
        end
        if (tb_w >= ONE6)
        begin
            tb_w = tb_w - ONE6;
        end
        t2_next[0] = tr_w[18:0];
        t2_next[1] = tg_w[18:0];
        t2_next[2] = tb_w[18:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat2_reg <= sat2_next;
            val2_reg <= val2_next;
            t2_reg <= t2_next;
        end
    end

    // stage 3: ramp per channel
    always_comb
    begin
        pdist = '0;
        for (int k = 0; k < 3; k++)
        begin
            pdist = (t2_reg[k] >= ONE3) ? 18'(t2_reg[k] - ONE3) : 18'(ONE3 - t2_reg[k]);
            if (pdist > 18'(pha_pkg::ONE))
            begin
                if (pdist - 18'(pha_pkg::ONE) > 18'(pha_pkg::ONE))
                begin
                    ramp3_next[k] = pha_pkg::ONE;
                end
                else
                begin
                    ramp3_next[k] = pha_pkg::CW'(pdist - 18'(pha_pkg::ONE));
                end
            end
            else
            begin
                ramp3_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat3_reg <= sat2_reg;
            val3_reg <= val2_reg;
            ramp3_reg <= ramp3_next;
        end
    end

    // stage 4: saturation term
    always_comb
    begin
        mprod = '0;
        for (int k = 0; k < 3; k++)
        begin
            mprod = sat3_reg * (pha_pkg::ONE - ramp3_reg[k]);
            m4_next[k] = mprod[32:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val4_reg <= val3_reg;
            m4_reg <= m4_next;
        end
    end

    // stage 5: adjusted channel
    always_comb
    begin
        cprod = '0;
        for (int k = 0; k < 3; k++)
        begin
            cprod = val4_reg * (pha_pkg::ONE - m4_reg[k]);
            adj5_next[k] = cprod[32:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adj5_reg <= adj5_next;
        end
    end

    // stage 6: blend products, original weight may go negative
    assign wneg = 19'sd65536 - $signed({2'b00, cfg.blend_weight});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa6_reg[k] <= $signed({1'b0, lin_reg[4][k]}) * wneg;
                pb6_reg[k] <= adj5_reg[k] * cfg.blend_weight;
            end
        end
    end

    // stage 7: sum, scale by 255/2^32, saturate to a byte
    always_comb
    begin
        num = '0;
        scaled = '0;
        for (int k = 0; k < 3; k++)
        begin
            num = $signed({pa6_reg[k][36], pa6_reg[k]}) + $signed({4'b0000, pb6_reg[k]});
            scaled = (46'(num[36:0]) << 8) - 46'(num[36:0]);
            if (num <= 38'sd0)
            begin
                out7_next[k] = '0;
            end
            else if (scaled[45:32] > 14'd255)
            begin
                out7_next[k] = 8'hFF;
            end
            else
            begin
                out7_next[k] = scaled[39:32];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out7_reg <= out7_next;
            alpha7_reg <= alpha_reg[5];
        end
    end

    assign pixel.red_out = out7_reg[0];
    assign pixel.green_out = out7_reg[1];
    assign pixel.blue_out = out7_reg[2];
    assign pixel.alpha_out = alpha7_reg;
    assign out_valid = v_reg[6];

endmodule

// ----- hdl/pixel_hsv_adjust_core.sv -----
// top level of the pixel hsv adjust core: config registers and pipeline glue
// pixel path: front stages, then the divider, then back stages, from pixel transaction to result
// throughput: one texel per cycle; the whole pipeline holds while the result waits
// the 17-stage hue/saturation divider sets the depth, one quotient bit per stage
// reset: asynchronous active low, clears valid bits and loads register defaults
// configuration writes are always taken and must happen while the pipeline is empty
module pixel_hsv_adjust_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  pha_pkg::pixel_in_t  pixel,
    output logic                result_valid,
    input  logic                result_ready,
    output pha_pkg::pixel_out_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [16:0]         cfg_data
);

    pha_pkg::cfg_t      cfg_reg;
    logic               en;
    logic               front_valid;
    pha_pkg::div_in_t   front_data;
    logic               div_valid;
    pha_pkg::hsv_t      div_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_setting <= 17'd32768;
            cfg_reg.saturation_gain <= 16'd256;
            cfg_reg.value_gain <= 16'd256;
            cfg_reg.blend_weight <= 17'd65536;
            cfg_reg.source_is_srgb <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (pha_pkg::cfg_index_t'(cfg_index))
                pha_pkg::REG_HUE_SETTING:     cfg_reg.hue_setting <= cfg_data;
                pha_pkg::REG_SATURATION_GAIN: cfg_reg.saturation_gain <= cfg_data[15:0];
                pha_pkg::REG_VALUE_GAIN:      cfg_reg.value_gain <= cfg_data[15:0];
                pha_pkg::REG_BLEND_WEIGHT:    cfg_reg.blend_weight <= cfg_data;
                pha_pkg::REG_SOURCE_IS_SRGB:  cfg_reg.source_is_srgb <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline advances unless a finished result is held
    assign en = !result_valid || result_ready;
    assign pixel_ready = en;

    pha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pixel_valid),
        .pixel     (pixel),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .dout      (front_data)
    );

    pha_hsdiv u_hsdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .din       (front_data),
        .out_valid (div_valid),
        .dout      (div_data)
    );

    pha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .hsv       (div_data),
        .cfg       (cfg_reg),
        .out_valid (result_valid),
        .pixel     (result)
    );

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !pixel_ready)
        else $error("input taken while result stalled");
    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");
    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(front_valid) && $stable(div_valid))
        else $error("pipeline advanced during a stall");
`endif

endmodule
